@@ hdl/tkmd_pkg.sv @@
package tkmd_pkg;

  // Default depth of the mouse report buffer, counted in report bytes.
  localparam int unsigned ESCAPE_CAPACITY_DEF = 32;

  // Bytes with a special meaning in the terminal stream.
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_CSI   = "[";
  localparam logic [7:0] BYTE_SGR   = "<";
  localparam logic [7:0] BYTE_UP    = "A";
  localparam logic [7:0] BYTE_DOWN  = "B";
  localparam logic [7:0] BYTE_PRESS = "M";
  localparam logic [7:0] BYTE_REL   = "m";
  localparam logic [7:0] BYTE_SEP   = ";";
  localparam logic [7:0] BYTE_PLUS  = "+";
  localparam logic [7:0] BYTE_MINUS = "-";
  localparam logic [7:0] BYTE_ZERO  = "0";
  localparam logic [7:0] BYTE_NINE  = "9";
  localparam logic [7:0] BYTE_SPACE = " ";
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_LF    = 8'h0a;

  localparam int unsigned MAG_W = 15;
  localparam int unsigned POS_W = 16;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_SEEN  = 2'd1,
    ESC_CSI   = 2'd2,
    ESC_MOUSE = 2'd3
  } tkmd_esc_e;

  typedef enum logic [2:0] {
    SCAN_WAIT   = 3'd0,
    SCAN_SIGN   = 3'd1,
    SCAN_DIGITS = 3'd2,
    SCAN_DONE   = 3'd3,
    SCAN_FAIL   = 3'd4
  } tkmd_scan_e;

  typedef enum logic [3:0] {
    ACT_QUIT       = 4'd0,
    ACT_REFRESH    = 4'd1,
    ACT_FIXTURE    = 4'd2,
    ACT_VISUAL     = 4'd3,
    ACT_GEOGRAPHY  = 4'd4,
    ACT_ARRIVALS   = 4'd5,
    ACT_DEPARTURES = 4'd6,
    ACT_BACK       = 4'd7,
    ACT_OPEN       = 4'd8,
    ACT_UP         = 4'd9,
    ACT_DOWN       = 4'd10,
    ACT_MOUSE      = 4'd11
  } tkmd_action_e;

  // Commands from the escape sequencer to the report scanner.
  typedef struct packed {
    logic start;  // ESC [ < seen: clear the report
    logic drop;   // report hit the capacity: forget the byte count
    logic step;   // one more report byte to scan
  } tkmd_rep_ctrl_t;

  // What the scanner reports back about the report so far.
  typedef struct packed {
    logic             full;
    logic             matched;
    logic             btn_zero;
    logic [POS_W-1:0] pend_col;
    logic [POS_W-1:0] row_val;
  } tkmd_rep_stat_t;

endpackage

@@ hdl/tkmd_report.sv @@
module tkmd_report
  import tkmd_pkg::*;
#(
  parameter int unsigned ESCAPE_CAPACITY = ESCAPE_CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tkmd_rep_ctrl_t ctrl_i,
  input  logic [7:0]     byte_i,
  output tkmd_rep_stat_t stat_o
);

  localparam int unsigned CntW = $clog2(ESCAPE_CAPACITY + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW:0]    count_inc;
  tkmd_scan_e       phase_q, phase_d;
  logic [1:0]       idx_q, idx_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [1:0]       btn_q, btn_d;
  logic [POS_W-1:0] pcol_q, pcol_d;

  logic [POS_W-1:0] sval;
  logic             is_digit;
  logic             is_space;
  logic [3:0]       dval;
  logic [MAG_W+3:0] mag_next;
  logic [MAG_W-1:0] mag_sat;

  assign count_inc = {1'b0, count_q} + (CntW + 1)'(1);
  assign sval      = neg_q ? (POS_W'(0) - {1'b0, mag_q}) : {1'b0, mag_q};
  assign is_digit  = (byte_i >= BYTE_ZERO) && (byte_i <= BYTE_NINE);
  assign is_space  = (byte_i == BYTE_SPACE) || ((byte_i >= BYTE_TAB) && (byte_i <= BYTE_CR));
  assign dval      = byte_i[3:0];
  // Times ten is two shifts and an add.
  assign mag_next  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {15'b0, dval};
  assign mag_sat   = (mag_next > (MAG_W + 4)'(2 ** MAG_W - 1)) ? '1 : mag_next[MAG_W-1:0];

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    btn_d   = btn_q;
    pcol_d  = pcol_q;
    if (ctrl_i.start) begin
      count_d = '0;
      phase_d = SCAN_WAIT;
      idx_d   = '0;
      mag_d   = '0;
      neg_d   = 1'b0;
      btn_d   = '0;
      pcol_d  = '0;
    end else if (ctrl_i.drop) begin
      count_d = '0;
    end else if (ctrl_i.step) begin
      count_d = count_inc[CntW-1:0];
      if (phase_q == SCAN_DONE || phase_q == SCAN_FAIL) begin
        // Outcome already settled; later bytes only count.
      end else if (byte_i == BYTE_NUL) begin
        // End of text, as a NUL ends the string handed to the scanner.
        phase_d = (phase_q == SCAN_DIGITS && idx_q == 2'd2) ? SCAN_DONE : SCAN_FAIL;
      end else begin
        unique case (phase_q)
          SCAN_WAIT: begin
            if (is_space) begin
              phase_d = SCAN_WAIT;
            end else if (byte_i == BYTE_PLUS || byte_i == BYTE_MINUS) begin
              neg_d   = (byte_i == BYTE_MINUS);
              phase_d = SCAN_SIGN;
            end else if (is_digit) begin
              mag_d   = MAG_W'(dval);
              phase_d = SCAN_DIGITS;
            end else begin
              phase_d = SCAN_FAIL;
            end
          end
          SCAN_SIGN: begin
            if (is_digit) begin
              mag_d   = MAG_W'(dval);
              phase_d = SCAN_DIGITS;
            end else begin
              phase_d = SCAN_FAIL;
            end
          end
          SCAN_DIGITS: begin
            if (is_digit) begin
              mag_d = mag_sat;
            end else if (idx_q == 2'd2) begin
              phase_d = SCAN_DONE;
            end else if (byte_i != BYTE_SEP) begin
              phase_d = SCAN_FAIL;
            end else begin
              if (idx_q == 2'd0) begin
                btn_d = sval[1:0];
              end else begin
                pcol_d = sval - POS_W'(1);
              end
              idx_d   = idx_q + 2'd1;
              phase_d = SCAN_WAIT;
              mag_d   = '0;
              neg_d   = 1'b0;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= SCAN_WAIT;
      idx_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      btn_q   <= '0;
      pcol_q  <= '0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      btn_q   <= btn_d;
      pcol_q  <= pcol_d;
    end
  end

  assign stat_o.full     = count_inc >= (CntW + 1)'(ESCAPE_CAPACITY);
  assign stat_o.matched  = (phase_q == SCAN_DONE) || (phase_q == SCAN_DIGITS && idx_q == 2'd2);
  assign stat_o.btn_zero = (btn_q == 2'd0);
  assign stat_o.pend_col = pcol_q;
  assign stat_o.row_val  = sval - POS_W'(1);

endmodule

@@ hdl/terminal_key_and_mouse_decoder.sv @@
// A byte accepted into the input stage then loads its result, if any, into the result register,
// unless the result register is still stalled, in which case the byte waits in the input stage.
// Throughput: one byte per cycle while results are taken. A byte that gives no result
// moves on even while a result waits on the output; a byte with a result holds the input.
// Reset (rst_ni low, asynchronous): no escape in progress, report state cleared, and
// the last mouse column and row both read as minus one.
module terminal_key_and_mouse_decoder
  import tkmd_pkg::*;
#(
  parameter int unsigned ESCAPE_CAPACITY = ESCAPE_CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       action_o,
  output logic [POS_W-1:0] mouse_column_o,
  output logic [POS_W-1:0] mouse_row_o
);

  // Input stage: the byte waiting to be decoded.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // Escape sequencer state and the position of the last mouse press.
  tkmd_esc_e        esc_q, esc_d;
  logic [POS_W-1:0] last_col_q, last_col_d;
  logic [POS_W-1:0] last_row_q, last_row_d;

  // Result register.
  logic             out_valid_q;
  tkmd_action_e     act_q;
  logic [POS_W-1:0] col_q, row_q;

  tkmd_action_e   act_d;
  logic           has_res;
  tkmd_rep_ctrl_t rep_ctrl, rep_ctrl_gated;
  tkmd_rep_stat_t rep_stat;

  logic out_free;
  logic advance;

  // The result register can take a new result when it is empty or being emptied.
  // A byte that gives no result moves on regardless of the output side.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (!has_res || out_free);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= byte_value_i;
    end
  end

  // The mouse report itself is scanned number by number in a unit of its own;
  // it only changes state when the current byte actually moves on.
  assign rep_ctrl_gated = advance ? rep_ctrl : '0;

  tkmd_report #(
    .ESCAPE_CAPACITY(ESCAPE_CAPACITY)
  ) u_report (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rep_ctrl_gated),
    .byte_i (s1_byte_q),
    .stat_o (rep_stat)
  );

  // Escape sequencer: next state, key decoding and result selection.
  always_comb begin
    esc_d      = esc_q;
    act_d      = ACT_QUIT;
    has_res    = 1'b0;
    rep_ctrl   = '0;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    unique case (esc_q)
      ESC_IDLE: begin
        if (s1_byte_q == BYTE_ESC) begin
          esc_d = ESC_SEEN;
        end else begin
          // Plain key: letters in either case, and CR or LF for open.
          has_res = 1'b1;
          unique case (s1_byte_q)
            "q", "Q":         act_d = ACT_QUIT;
            "r", "R":         act_d = ACT_REFRESH;
            "f", "F":         act_d = ACT_FIXTURE;
            "v", "V":         act_d = ACT_VISUAL;
            "g", "G":         act_d = ACT_GEOGRAPHY;
            "a", "A":         act_d = ACT_ARRIVALS;
            "d", "D":         act_d = ACT_DEPARTURES;
            "b", "B":         act_d = ACT_BACK;
            BYTE_CR, BYTE_LF: act_d = ACT_OPEN;
            default:          has_res = 1'b0;
          endcase
        end
      end
      ESC_SEEN: begin
        // Anything other than the bracket abandons the escape quietly.
        esc_d = (s1_byte_q == BYTE_CSI) ? ESC_CSI : ESC_IDLE;
      end
      ESC_CSI: begin
        if (s1_byte_q == BYTE_SGR) begin
          esc_d          = ESC_MOUSE;
          rep_ctrl.start = 1'b1;
        end else begin
          esc_d = ESC_IDLE;
          if (s1_byte_q == BYTE_UP) begin
            has_res = 1'b1;
            act_d   = ACT_UP;
          end else if (s1_byte_q == BYTE_DOWN) begin
            has_res = 1'b1;
            act_d   = ACT_DOWN;
          end
        end
      end
      ESC_MOUSE: begin
        if (s1_byte_q == BYTE_PRESS || s1_byte_q == BYTE_REL) begin
          esc_d = ESC_IDLE;
          // Only a complete press of the primary button moves the position;
          // a release or an incomplete report keeps the previous one.
          if (rep_stat.matched && rep_stat.btn_zero && s1_byte_q == BYTE_PRESS) begin
            has_res    = 1'b1;
            act_d      = ACT_MOUSE;
            last_col_d = rep_stat.pend_col;
            last_row_d = rep_stat.row_val;
          end
        end else if (rep_stat.full) begin
          // Report too long for the buffer: drop it without a result.
          esc_d         = ESC_IDLE;
          rep_ctrl.drop = 1'b1;
        end else begin
          rep_ctrl.step = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= ESC_IDLE;
      last_col_q <= '1;
      last_row_q <= '1;
    end else if (advance) begin
      esc_q      <= esc_d;
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
    end
  end

  // Result register: loads a new result, or empties once the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      act_q <= act_d;
      col_q <= last_col_d;
      row_q <= last_row_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = act_q;
  assign mouse_column_o = col_q;
  assign mouse_row_o    = row_q;

  // A waiting byte with a result must hold while the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && has_res && out_valid_q && !out_ready_i) |-> (!in_ready_o && !advance))
    else $error("byte advanced over a stalled result");

  // The position in a pending result is always the last stored press position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (col_q == last_col_q && row_q == last_row_q))
    else $error("result position differs from stored press position");

  // The stored position only changes together with a mouse result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_col_q != $past(last_col_q) || last_row_q != $past(last_row_q))
      |-> (out_valid_q && act_q == ACT_MOUSE))
    else $error("press position changed without a mouse result");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tkmd_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1550;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  // The receiver holds off for this window of its own cycles, so that the output
  // register and then the input register fill up and the sender is stalled.
  localparam int unsigned HOLD_FIRST     = 1000;
  localparam int unsigned HOLD_LAST      = 1300;

  typedef struct {
    tkmd_action_e     action;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } decoded_event_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [7:0]       byte_value_i = 8'h00;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [3:0]       action_o;
  logic [POS_W-1:0] mouse_column_o;
  logic [POS_W-1:0] mouse_row_o;

  logic [7:0]     pending_bytes[$];
  decoded_event_t expected_events[$];
  int unsigned    bytes_sent   = 0;
  int unsigned    error_count  = 0;
  int unsigned    stall_cycles = 0;
  int unsigned    rx_cycle     = 0;

  // Our own copy of the decoder state, as it stands just after reset.
  tkmd_esc_e        esc_state = ESC_IDLE;
  tkmd_scan_e       scan_st   = SCAN_WAIT;
  int unsigned      rep_count = 0;
  logic [1:0]       num_idx   = '0;
  logic [MAG_W-1:0] mag       = '0;
  logic             neg       = 1'b0;
  logic [1:0]       btn_bits  = '0;
  logic [POS_W-1:0] pend_col  = '0;
  logic [POS_W-1:0] last_col  = '1;
  logic [POS_W-1:0] last_row  = '1;

  terminal_key_and_mouse_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .mouse_column_o (mouse_column_o),
    .mouse_row_o    (mouse_row_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The number being scanned, with its sign applied, in 16-bit two's complement.
  function automatic logic [POS_W-1:0] scanned_value();
    return neg ? (POS_W'(0) - {1'b0, mag}) : {1'b0, mag};
  endfunction

  // Advances the decoder copy by one accepted byte and queues the event, if any,
  // that the block must report for it.
  function automatic void decode_byte(logic [7:0] c);
    tkmd_action_e     act;
    bit               emit;
    bit               digit;
    int               wide;
    logic [POS_W-1:0] sval;
    emit = 1'b0;
    act = ACT_QUIT;
    digit = (c >= BYTE_ZERO) && (c <= BYTE_NINE);
    case (esc_state)
      ESC_IDLE: begin
        emit = 1'b1;
        case (c)
          BYTE_ESC: begin
            esc_state = ESC_SEEN;
            emit = 1'b0;
          end
          "q", "Q": act = ACT_QUIT;
          "r", "R": act = ACT_REFRESH;
          "f", "F": act = ACT_FIXTURE;
          "v", "V": act = ACT_VISUAL;
          "g", "G": act = ACT_GEOGRAPHY;
          "a", "A": act = ACT_ARRIVALS;
          "d", "D": act = ACT_DEPARTURES;
          "b", "B": act = ACT_BACK;
          BYTE_CR, BYTE_LF: act = ACT_OPEN;
          default: emit = 1'b0;
        endcase
      end
      ESC_SEEN: esc_state = (c == BYTE_CSI) ? ESC_CSI : ESC_IDLE;
      ESC_CSI: begin
        if (c == BYTE_SGR) begin
          // A fresh mouse report: everything scanned so far is forgotten.
          esc_state = ESC_MOUSE;
          rep_count = 0;
          num_idx = '0;
          scan_st = SCAN_WAIT;
          mag = '0;
          neg = 1'b0;
          btn_bits = '0;
          pend_col = '0;
        end else begin
          esc_state = ESC_IDLE;
          if (c == BYTE_UP) begin
            act = ACT_UP;
            emit = 1'b1;
          end else if (c == BYTE_DOWN) begin
            act = ACT_DOWN;
            emit = 1'b1;
          end
        end
      end
      default: begin
        if (c == BYTE_PRESS || c == BYTE_REL) begin
          esc_state = ESC_IDLE;
          // Only a press of a button whose low bits are clear, with all three
          // numbers present, moves the stored position.
          if ((scan_st == SCAN_DONE || (scan_st == SCAN_DIGITS && num_idx == 2)) &&
              btn_bits == 2'd0 && c == BYTE_PRESS) begin
            last_col = pend_col;
            last_row = scanned_value() - POS_W'(1);
            act = ACT_MOUSE;
            emit = 1'b1;
          end
        end else if (rep_count + 1 >= ESCAPE_CAPACITY_DEF) begin
          // The report would overflow the buffer, so it is dropped silently.
          esc_state = ESC_IDLE;
          rep_count = 0;
        end else begin
          rep_count++;
          if (scan_st == SCAN_DONE || scan_st == SCAN_FAIL) begin
            // The outcome is settled; later bytes only count toward the capacity.
          end else if (c == BYTE_NUL) begin
            scan_st = (scan_st == SCAN_DIGITS && num_idx == 2) ? SCAN_DONE : SCAN_FAIL;
          end else if (scan_st == SCAN_WAIT) begin
            if (c == BYTE_SPACE || (c >= BYTE_TAB && c <= BYTE_CR)) begin
              // Leading whitespace is skipped.
            end else if (c == BYTE_PLUS || c == BYTE_MINUS) begin
              neg = (c == BYTE_MINUS);
              scan_st = SCAN_SIGN;
            end else if (digit) begin
              mag = MAG_W'(c - BYTE_ZERO);
              scan_st = SCAN_DIGITS;
            end else begin
              scan_st = SCAN_FAIL;
            end
          end else if (scan_st == SCAN_SIGN) begin
            if (digit) begin
              mag = MAG_W'(c - BYTE_ZERO);
              scan_st = SCAN_DIGITS;
            end else begin
              scan_st = SCAN_FAIL;
            end
          end else if (digit) begin
            wide = int'(mag) * 10 + int'(c - BYTE_ZERO);
            mag = (wide > 32767) ? MAG_W'(32767) : MAG_W'(wide);
          end else if (num_idx == 2) begin
            scan_st = SCAN_DONE;
          end else if (c != BYTE_SEP) begin
            scan_st = SCAN_FAIL;
          end else begin
            sval = scanned_value();
            if (num_idx == 0) btn_bits = sval[1:0];
            else pend_col = sval - POS_W'(1);
            num_idx++;
            scan_st = SCAN_WAIT;
            mag = '0;
            neg = 1'b0;
          end
        end
      end
    endcase
    if (emit) expected_events.push_back('{act, last_col, last_row});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endfunction

  function automatic void push_space();
    pending_bytes.push_back($urandom_range(1) ? BYTE_SPACE : 8'($urandom_range(9, 13)));
  endfunction

  // Writes one decimal number as a terminal would, now and then with the
  // whitespace, explicit plus sign or leading zero that the scan tolerates.
  function automatic void push_number(int value);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) push_space();
    if (value < 0) pending_bytes.push_back(BYTE_MINUS);
    else if ($urandom_range(7) == 0) pending_bytes.push_back(BYTE_PLUS);
    if ($urandom_range(9) == 0) pending_bytes.push_back(BYTE_ZERO);
    push_text($sformatf("%0d", (value < 0) ? -value : value));
  endfunction

  function automatic int coordinate();
    if ($urandom_range(9) != 0) return $urandom_range(1, 300);
    case ($urandom_range(5))
      0: return 0;
      1: return -$urandom_range(1, 40);
      2: return 32767;
      3: return 32768 + $urandom_range(0, 67231);
      4: return -99999;
      default: return 1;
    endcase
  endfunction

  // A mouse report in the SGR form, mostly well formed, with random content.
  function automatic void push_mouse_report();
    int btn;
    btn = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : 4 * $urandom_range(0, 16);
    pending_bytes.push_back(BYTE_ESC);
    push_text("[<");
    // Long padding takes the report to, or over, the edge of the buffer.
    if ($urandom_range(11) == 0) repeat ($urandom_range(20, 31)) push_space();
    push_number(btn);
    pending_bytes.push_back(BYTE_SEP);
    push_number(coordinate());
    pending_bytes.push_back(BYTE_SEP);
    push_number(coordinate());
    case ($urandom_range(11))
      0: pending_bytes.push_back(BYTE_NUL);
      1: push_text(";9");
      2: push_text("x");
      default: ;
    endcase
    pending_bytes.push_back(($urandom_range(4) != 0) ? BYTE_PRESS : BYTE_REL);
  endfunction

  // A report made of bytes that mostly do not fit the expected form.
  function automatic void push_broken_report();
    string alphabet;
    alphabet = "0123456789;;;+- x";
    pending_bytes.push_back(BYTE_ESC);
    push_text("[<");
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(5))
        0: pending_bytes.push_back(8'($urandom_range(0, 255)));
        1: pending_bytes.push_back(BYTE_NUL);
        default: pending_bytes.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
      endcase
    end
    pending_bytes.push_back($urandom_range(1) ? BYTE_PRESS : BYTE_REL);
  endfunction

  // Sender: presents the next queued byte whenever the channel is free, unless
  // it chooses to idle. Each accepted byte is fed to the predictor here.
  always @(posedge clk_i) begin : sender
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(byte_value_i);
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        // Between the 600th and the 900th byte the sender never idles.
        if (pending_bytes.size() > 0 &&
            ((bytes_sent >= 600 && bytes_sent < 900) || $urandom_range(99) >= 31)) begin
          in_valid_i <= 1'b1;
          byte_value_i <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: takes results at random, never stalls for a while, and holds off
  // for one long stretch. Every accepted result is checked against the oldest
  // expected event.
  always @(posedge clk_i) begin : receiver
    decoded_event_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result: action %0d column %0d row %0d", $time,
                   action_o, $signed(mouse_column_o), $signed(mouse_row_o));
        end else begin
          want = expected_events.pop_front();
          if (action_o !== want.action || mouse_column_o !== want.column ||
              mouse_row_o !== want.row) begin
            error_count++;
            $display("%0t ns: mismatch: expected action %0d column %0d row %0d, got %0d %0d %0d",
                     $time, want.action, $signed(want.column), $signed(want.row),
                     action_o, $signed(mouse_column_o), $signed(mouse_row_o));
          end
        end
      end
      if (rx_cycle >= HOLD_FIRST && rx_cycle < HOLD_LAST) out_ready_i <= 1'b0;
      else if (rx_cycle >= 400 && rx_cycle < 700) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(99) >= 31);
    end
  end

  // Watchdog: counts the cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    int unsigned stimulus_total;
    bit          timed_out;
    string       keys;
    keys = "qQrRfFvVgGaAdDbB\r\n";

    // Directed opening: every key, both line ends, the extreme byte values, the
    // arrow keys, both kinds of abandoned escape, and one small mouse press.
    push_text("QrFvGaDb\r\n");
    pending_bytes.push_back(8'hff);
    pending_bytes.push_back(BYTE_NUL);
    push_text("x");
    pending_bytes.push_back(BYTE_ESC);
    push_text("[A");
    pending_bytes.push_back(BYTE_ESC);
    push_text("[B");
    pending_bytes.push_back(BYTE_ESC);
    push_text("Z");
    pending_bytes.push_back(BYTE_ESC);
    push_text("[z");
    pending_bytes.push_back(BYTE_ESC);
    push_text("[<0;1;1M");

    while (pending_bytes.size() < ITEM_TARGET) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: push_mouse_report();
        9, 10: push_broken_report();
        11, 12: begin
          pending_bytes.push_back(BYTE_ESC);
          if ($urandom_range(3) == 0) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
          end else begin
            pending_bytes.push_back(BYTE_CSI);
            case ($urandom_range(2))
              0: pending_bytes.push_back(BYTE_UP);
              1: pending_bytes.push_back(BYTE_DOWN);
              default: pending_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
          end
        end
        13, 14, 15, 16: pending_bytes.push_back(keys[$urandom_range(keys.len() - 1)]);
        default: pending_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    stimulus_total = pending_bytes.size();

    // Reset is released on a falling edge, well away from the edge the block
    // samples on.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(bytes_sent == stimulus_total && expected_events.size() == 0) &&
           stall_cycles < WATCHDOG_LIMIT)
      @(posedge clk_i);
    timed_out = (stall_cycles >= WATCHDOG_LIMIT);
    // The drain period catches any result the block should not have produced.
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!timed_out && error_count == 0 && expected_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tkmd_pkg.sv
hdl/tkmd_report.sv
hdl/terminal_key_and_mouse_decoder.sv
dv/testbench.sv
